### sv/esc_pkg.sv
`timescale 1ns / 1ps

package esc_pkg;

  localparam int YEAR_SPAN_DEF = 136;
  localparam int YEAR_W        = 8;
  localparam int DAYS_W        = 16;
  localparam int YDAY_W        = 9;
  localparam int TAB_DEPTH     = 256;
  localparam int EPOCH_YEAR    = 1970;
  localparam int YEAR_BASE     = 1900;
  localparam int DAYS_PER_YEAR = 365;

  localparam int SECS_PER_MIN  = 60;
  localparam int MINS_PER_HOUR = 60;
  localparam int HOURS_PER_DAY = 24;

  // reciprocals: x/15 = (x * DIV15_MUL) >> 35, x/3 = (x * DIV3_MUL) >> 33
  localparam logic [31:0] DIV15_MUL = 32'h8888_8889;
  localparam logic [31:0] DIV3_MUL  = 32'hAAAA_AAAB;

  typedef logic [16:0] ystart_tab_t [TAB_DEPTH];
  typedef logic [YDAY_W-1:0] month_tab_t [2][12];

  function automatic int leaps_before(int year);
    int p;
    p = year - 1;
    return p / 4 - p / 100 + p / 400;
  endfunction

  function automatic logic is_leap(int year);
    return ((year % 4) == 0) && (((year % 100) != 0) || ((year % 400) == 0));
  endfunction

  function automatic ystart_tab_t build_year_start();
    ystart_tab_t tab;
    for (int y = 0; y < TAB_DEPTH; y++) begin
      tab[y] = 17'(y * DAYS_PER_YEAR + leaps_before(EPOCH_YEAR + y)
                   - leaps_before(EPOCH_YEAR));
    end
    return tab;
  endfunction

  function automatic logic [TAB_DEPTH-1:0] build_leap_map();
    logic [TAB_DEPTH-1:0] map;
    for (int y = 0; y < TAB_DEPTH; y++) begin
      map[y] = is_leap(EPOCH_YEAR + y);
    end
    return map;
  endfunction

  // first day of each year offset, counted from the epoch
  localparam ystart_tab_t YEAR_START = build_year_start();
  localparam logic [TAB_DEPTH-1:0] LEAP_MAP = build_leap_map();

  localparam month_tab_t MONTH_START = '{
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334},
    '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335}
  };

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic              valid;
    logic [DAYS_W-1:0] days;
    tod_t              tod;
  } day_word_t;

  typedef struct packed {
    logic              valid;
    logic [DAYS_W-1:0] days;
    logic [YEAR_W-1:0] yoff;
    logic              oor;
    tod_t              tod;
  } year_word_t;

  typedef struct packed {
    logic              valid;
    logic [YEAR_W-1:0] yoff;
    logic              oor;
    logic              leap;
    logic [3:0]        month;
    logic [YDAY_W-1:0] yday;
    tod_t              tod;
  } date_word_t;

endpackage

### sv/esc_time_split.sv
`timescale 1ns / 1ps

module esc_time_split (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [31:0]           epoch_seconds,
  output esc_pkg::day_word_t    day_word
);

  // stage 1: seconds / 60
  logic        v1_r;
  logic [26:0] q1_r;
  logic [5:0]  x_lo_r;
  // stage 2: minutes / 60, seconds remainder
  logic        v2_r;
  logic [20:0] q2_r;
  logic [5:0]  q1_lo_r;
  logic [5:0]  sec2_r;
  // stage 3: hours / 24, minutes remainder
  logic        v3_r;
  logic [15:0] days3_r;
  logic [4:0]  q2_lo_r;
  logic [5:0]  min3_r;
  logic [5:0]  sec3_r;
  // stage 4: hours remainder
  logic        v4_r;
  logic [15:0] days4_r;
  logic [4:0]  hour4_r;
  logic [5:0]  min4_r;
  logic [5:0]  sec4_r;

  logic [61:0] p1;
  logic [56:0] p2;
  logic [49:0] p3;
  logic [26:0] q1_nxt;
  logic [20:0] q2_nxt;
  logic [15:0] days_nxt;
  logic [26:0] q1_x60;
  logic [20:0] q2_x60;
  logic [15:0] days_x24;
  logic [5:0]  sec_nxt;
  logic [5:0]  min_nxt;
  logic [4:0]  hour_nxt;

  // x/60 = (x>>2)/15, x/24 = (x>>3)/3
  assign p1       = 62'(epoch_seconds[31:2]) * 62'(esc_pkg::DIV15_MUL);
  assign q1_nxt   = p1[61:35];
  assign p2       = 57'(q1_r[26:2]) * 57'(esc_pkg::DIV15_MUL);
  assign q2_nxt   = p2[55:35];
  assign p3       = 50'(q2_r[20:3]) * 50'(esc_pkg::DIV3_MUL);
  assign days_nxt = p3[48:33];

  // remainders are small, so only the low bits matter
  assign q1_x60   = q1_r * 27'(esc_pkg::SECS_PER_MIN);
  assign sec_nxt  = x_lo_r - q1_x60[5:0];
  assign q2_x60   = q2_r * 21'(esc_pkg::MINS_PER_HOUR);
  assign min_nxt  = q1_lo_r - q2_x60[5:0];
  assign days_x24 = days3_r * 16'(esc_pkg::HOURS_PER_DAY);
  assign hour_nxt = q2_lo_r - days_x24[4:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r    <= q1_nxt;
      x_lo_r  <= epoch_seconds[5:0];
      q2_r    <= q2_nxt;
      q1_lo_r <= q1_r[5:0];
      sec2_r  <= sec_nxt;
      days3_r <= days_nxt;
      q2_lo_r <= q2_r[4:0];
      min3_r  <= min_nxt;
      sec3_r  <= sec2_r;
      days4_r <= days3_r;
      hour4_r <= hour_nxt;
      min4_r  <= min3_r;
      sec4_r  <= sec3_r;
    end
  end

  assign day_word.valid      = v4_r;
  assign day_word.days       = days4_r;
  assign day_word.tod.hour   = hour4_r;
  assign day_word.tod.minute = min4_r;
  assign day_word.tod.second = sec4_r;

endmodule

### sv/esc_year_search.sv
`timescale 1ns / 1ps

module esc_year_search #(
  parameter int YEAR_SPAN = esc_pkg::YEAR_SPAN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  esc_pkg::day_word_t   day_word,
  output esc_pkg::year_word_t  year_word
);

  localparam int STEPS = esc_pkg::YEAR_W;

  logic                        v_r    [STEPS];
  logic [esc_pkg::DAYS_W-1:0]  days_r [STEPS];
  logic [esc_pkg::YEAR_W-1:0]  yoff_r [STEPS];
  logic                        oor_r  [STEPS];
  esc_pkg::tod_t               tod_r  [STEPS];

  // one bit of the year offset per stage, msb first
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [esc_pkg::YEAR_W-1:0] BIT = esc_pkg::YEAR_W'(1 << (STEPS - 1 - k));

    logic                        cur_v;
    logic [esc_pkg::DAYS_W-1:0]  cur_days;
    logic [esc_pkg::YEAR_W-1:0]  cur_yoff;
    logic                        cur_oor;
    esc_pkg::tod_t               cur_tod;
    logic [esc_pkg::YEAR_W-1:0]  cand;
    logic                        hit;

    if (k == 0) begin : g_first
      assign cur_v    = day_word.valid;
      assign cur_days = day_word.days;
      assign cur_yoff = '0;
      assign cur_tod  = day_word.tod;
      assign cur_oor  = {1'b0, day_word.days} >=
                        esc_pkg::YEAR_START[esc_pkg::YEAR_W'(YEAR_SPAN)];
    end else begin : g_next
      assign cur_v    = v_r[k-1];
      assign cur_days = days_r[k-1];
      assign cur_yoff = yoff_r[k-1];
      assign cur_tod  = tod_r[k-1];
      assign cur_oor  = oor_r[k-1];
    end

    assign cand = cur_yoff | BIT;
    assign hit  = ({1'b0, cand} < 9'(YEAR_SPAN)) &&
                  (esc_pkg::YEAR_START[cand] <= {1'b0, cur_days});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        days_r[k] <= cur_days;
        yoff_r[k] <= hit ? cand : cur_yoff;
        oor_r[k]  <= cur_oor;
        tod_r[k]  <= cur_tod;
      end
    end
  end

  assign year_word.valid = v_r[STEPS-1];
  assign year_word.days  = days_r[STEPS-1];
  assign year_word.yoff  = yoff_r[STEPS-1];
  assign year_word.oor   = oor_r[STEPS-1];
  assign year_word.tod   = tod_r[STEPS-1];

endmodule

### sv/esc_month_find.sv
`timescale 1ns / 1ps

module esc_month_find (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  esc_pkg::year_word_t  year_word,
  output esc_pkg::date_word_t  date_word
);

  // stage a: day of year and leap flag
  logic                        va_r;
  logic [esc_pkg::YEAR_W-1:0]  yoff_a_r;
  logic                        oor_a_r;
  logic                        leap_a_r;
  logic [esc_pkg::YDAY_W-1:0]  yday_a_r;
  esc_pkg::tod_t               tod_a_r;
  // stage b: month
  logic                        vb_r;
  logic [esc_pkg::YEAR_W-1:0]  yoff_b_r;
  logic                        oor_b_r;
  logic                        leap_b_r;
  logic [3:0]                  month_b_r;
  logic [esc_pkg::YDAY_W-1:0]  yday_b_r;
  esc_pkg::tod_t               tod_b_r;

  logic [16:0] yday_full;
  logic [3:0]  month_nxt;

  assign yday_full = {1'b0, year_word.days} - esc_pkg::YEAR_START[year_word.yoff];

  always_comb begin
    month_nxt = '0;
    for (int k = 1; k < 12; k++) begin
      if (esc_pkg::MONTH_START[leap_a_r][k] <= yday_a_r) begin
        month_nxt = 4'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= year_word.valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yoff_a_r  <= year_word.yoff;
      oor_a_r   <= year_word.oor;
      leap_a_r  <= esc_pkg::LEAP_MAP[year_word.yoff];
      yday_a_r  <= yday_full[esc_pkg::YDAY_W-1:0];
      tod_a_r   <= year_word.tod;
      yoff_b_r  <= yoff_a_r;
      oor_b_r   <= oor_a_r;
      leap_b_r  <= leap_a_r;
      month_b_r <= month_nxt;
      yday_b_r  <= yday_a_r;
      tod_b_r   <= tod_a_r;
    end
  end

  assign date_word.valid = vb_r;
  assign date_word.yoff  = yoff_b_r;
  assign date_word.oor   = oor_b_r;
  assign date_word.leap  = leap_b_r;
  assign date_word.month = month_b_r;
  assign date_word.yday  = yday_b_r;
  assign date_word.tod   = tod_b_r;

endmodule

### sv/epoch_seconds_to_calendar.sv
// an accepted input word passes every pipeline stage listed below before it shows on out_valid
// throughput: one word per cycle; a waiting output word with out_ready low freezes every stage
// the 15-stage pipeline: 4 divide stages, 8 year search stages, 3 date stages
// reset (rst_n low, synchronous): all stage valid bits clear, data registers keep contents
`timescale 1ns / 1ps

module epoch_seconds_to_calendar #(
  parameter int YEAR_SPAN = esc_pkg::YEAR_SPAN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_years_since_1900,
  output logic [3:0]  out_month_index,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour_of_day,
  output logic [5:0]  out_minute_of_hour,
  output logic [5:0]  out_second_of_minute,
  output logic        out_of_range
);

  // global advance: the whole pipe moves when the output register is free or drained
  logic en;

  esc_pkg::day_word_t  day_word;
  esc_pkg::year_word_t year_word;
  esc_pkg::date_word_t date_word;

  logic       out_valid_r;
  logic [7:0] year_r;
  logic [3:0] month_r;
  logic [4:0] mday_r;
  logic [4:0] hour_r;
  logic [5:0] minute_r;
  logic [5:0] second_r;
  logic       oor_r;

  logic [esc_pkg::YDAY_W-1:0] mday_full;
  logic [esc_pkg::YEAR_W-1:0] year_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // seconds split into whole days and time of day
  esc_time_split u_split (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .epoch_seconds (in_epoch_seconds),
    .day_word      (day_word)
  );

  // binary search for the year whose first day is at or before the day count
  esc_year_search #(
    .YEAR_SPAN (YEAR_SPAN)
  ) u_year (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .day_word  (day_word),
    .year_word (year_word)
  );

  // day of year, then month from the cumulative month table
  esc_month_find u_month (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .year_word (year_word),
    .date_word (date_word)
  );

  // day of month from day of year minus the month start, counted from 1
  assign mday_full = date_word.yday
                     - esc_pkg::MONTH_START[date_word.leap][date_word.month]
                     + esc_pkg::YDAY_W'(1);
  assign year_nxt  = date_word.yoff
                     + esc_pkg::YEAR_W'(esc_pkg::EPOCH_YEAR - esc_pkg::YEAR_BASE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= date_word.valid;
    end
  end

  // out of range: date fields forced to zero, time of day still reported
  always_ff @(posedge clk) begin
    if (en) begin
      year_r   <= date_word.oor ? '0 : year_nxt;
      month_r  <= date_word.oor ? '0 : date_word.month;
      mday_r   <= date_word.oor ? '0 : mday_full[4:0];
      hour_r   <= date_word.tod.hour;
      minute_r <= date_word.tod.minute;
      second_r <= date_word.tod.second;
      oor_r    <= date_word.oor;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_years_since_1900 = year_r;
  assign out_month_index      = month_r;
  assign out_day_of_month     = mday_r;
  assign out_hour_of_day      = hour_r;
  assign out_minute_of_hour   = minute_r;
  assign out_second_of_minute = second_r;
  assign out_of_range         = oor_r;

endmodule

### bench/epoch_seconds_to_calendar_test.sv
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_test;

  localparam int SPAN        = esc_pkg::YEAR_SPAN_DEF;
  localparam int FIRST_YEAR  = 1970;
  localparam int SECS_PER_DAY = 86400;
  localparam int RANDOM_WORDS = 1800;
  localparam int HOLD_AFTER  = 600;   // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES = 40;   // well over the 15-stage pipeline depth
  localparam int IDLE_LIMIT  = 4000;  // cycles with no handshake on either channel

  // one calendar result, laid out like the result channel
  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] mday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       oor;
  } calendar_t;

  typedef struct {
    logic [31:0] secs;
    calendar_t   date;
  } pending_t;

  // holds the calendar dates still owed by the block, oldest first
  class date_checker;
    pending_t pending_dates[$];
    int       failures;

    static function bit leap_year(int unsigned yr);
      if (yr % 400 == 0) return 1'b1;
      if (yr % 100 == 0) return 1'b0;
      return (yr % 4 == 0);
    endfunction

    static function int unsigned year_len(int unsigned yr);
      return leap_year(yr) ? 366 : 365;
    endfunction

    static function int unsigned month_len(int unsigned yr, int unsigned mon);
      case (mon)
        1:           return leap_year(yr) ? 29 : 28;
        3, 5, 8, 10: return 30;
        default:     return 31;
      endcase
    endfunction

    // days from the epoch to the first of the given month
    static function int unsigned day_number(int unsigned yr, int unsigned mon);
      int unsigned d;
      d = 0;
      for (int unsigned y = FIRST_YEAR; y < yr; y++) d += year_len(y);
      for (int unsigned m = 0; m < mon; m++) d += month_len(yr, m);
      return d;
    endfunction

    // splits a second count into time of day, then walks years and months
    static function calendar_t split_epoch(logic [31:0] secs);
      calendar_t   r;
      int unsigned t;
      int unsigned days;
      int unsigned yr;
      int unsigned mon;
      r = '0;
      t = secs;
      r.second = 6'(t % 60);
      t = t / 60;
      r.minute = 6'(t % 60);
      t = t / 60;
      r.hour = 5'(t % 24);
      days = t / 24;
      yr = FIRST_YEAR;
      while (yr < FIRST_YEAR + SPAN && days >= year_len(yr)) begin
        days -= year_len(yr);
        yr++;
      end
      if (yr == FIRST_YEAR + SPAN) begin
        // past the span: date fields stay zero, time of day still valid
        r.oor = 1'b1;
      end else begin
        mon = 0;
        while (days >= month_len(yr, mon)) begin
          days -= month_len(yr, mon);
          mon++;
        end
        r.year  = 8'(yr - 1900);
        r.month = 4'(mon);
        r.mday  = 5'(days + 1);
      end
      return r;
    endfunction

    function void note_input(logic [31:0] secs);
      pending_t p;
      p.secs = secs;
      p.date = split_epoch(secs);
      pending_dates.push_back(p);
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act,
                                logic [31:0] secs);
      if (exp != act) begin
        $display("%0t: %s mismatch for input %0d: expected %0d, actual %0d",
                 $time, name, secs, exp, act);
        failures++;
      end
    endfunction

    function void check_result(calendar_t act);
      pending_t p;
      if (pending_dates.size() == 0) begin
        $display("%0t: result word with nothing expected: expected none, actual %h",
                 $time, act);
        failures++;
        return;
      end
      p = pending_dates.pop_front();
      compare_field("years_since_1900", p.date.year,   act.year,   p.secs);
      compare_field("month_index",      p.date.month,  act.month,  p.secs);
      compare_field("day_of_month",     p.date.mday,   act.mday,   p.secs);
      compare_field("hour_of_day",      p.date.hour,   act.hour,   p.secs);
      compare_field("minute_of_hour",   p.date.minute, act.minute, p.secs);
      compare_field("second_of_minute", p.date.second, act.second, p.secs);
      compare_field("out_of_range",     p.date.oor,    act.oor,    p.secs);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_years_since_1900;
  logic [3:0]  out_month_index;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour_of_day;
  logic [5:0]  out_minute_of_hour;
  logic [5:0]  out_second_of_minute;
  logic        out_of_range;

  date_checker sb = new();
  int          words_sent;
  int          results_seen;

  epoch_seconds_to_calendar DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_epoch_seconds     (in_epoch_seconds),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_years_since_1900 (out_years_since_1900),
    .out_month_index      (out_month_index),
    .out_day_of_month     (out_day_of_month),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute),
    .out_of_range         (out_of_range)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // offer one word, idling first for a random gap unless told otherwise
  task automatic send_word(input logic [31:0] secs, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // valid stays high across back-to-back words, never dropped in the same step
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (!in_ready);
    sb.note_input(secs);
    words_sent++;
  endtask

  // start of a calendar month, in seconds since the epoch
  function automatic logic [31:0] month_start_secs(int unsigned yr, int unsigned mon);
    return date_checker::day_number(yr, mon) * SECS_PER_DAY;
  endfunction

  // random word: uniform, near a year edge, near a month edge, or near and past the end of the span
  function automatic logic [31:0] random_word(logic [31:0] oor_start);
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom();
    if (r < 65)
      return month_start_secs($urandom_range(2105, FIRST_YEAR), 0)
             + $urandom_range(2 * SECS_PER_DAY) - SECS_PER_DAY;
    if (r < 85)
      return month_start_secs($urandom_range(2105, FIRST_YEAR), $urandom_range(11))
             + $urandom_range(2 * SECS_PER_DAY) - SECS_PER_DAY;
    return $urandom_range(32'hFFFF_FFFF, oor_start - 32'd200000);
  endfunction

  // result monitor: every accepted result word goes to the checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{out_years_since_1900, out_month_index, out_day_of_month,
                        out_hour_of_day, out_minute_of_hour, out_second_of_minute,
                        out_of_range});
      results_seen++;
    end
  end

  // receiver: random stalls, one long hold-off so the pipeline fills and
  // pushes back on the sender, and a stretch of steady ready
  initial begin
    int  stall;
    int  run;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else if (results_seen >= 1000 && results_seen < 1300) begin
        stall = 0;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      run = $urandom_range(8, 1);
      repeat (run) @(posedge clk);
    end
  end

  // watchdog: ends the run when neither channel moves for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // main sequence
  initial begin
    logic [31:0] directed[$];
    logic [31:0] oor_start;
    oor_start = month_start_secs(FIRST_YEAR + SPAN, 0);

    // synchronous reset held, then released
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes and time-of-day rollovers
    directed = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'hFFFF_FFFF};
    // leap day of a 400-year century, and the end of a leap year
    directed.push_back(month_start_secs(2000, 2) - 1);
    directed.push_back(month_start_secs(2000, 2));
    directed.push_back(month_start_secs(1973, 0) - 1);
    // century that is not a leap year
    directed.push_back(month_start_secs(2100, 2) - 1);
    directed.push_back(month_start_secs(2100, 2));
    directed.push_back(month_start_secs(2104, 2) - 1);
    // last month inside the span, last second inside, first second past it
    directed.push_back(month_start_secs(2105, 11));
    directed.push_back(oor_start - 1);
    directed.push_back(oor_start);
    directed.push_back(oor_start + 32'd86399);

    foreach (directed[i]) send_word(directed[i], 1'b0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // a run of back-to-back words with no sender gaps
      send_word(random_word(oor_start), (n >= 1000 && n < 1200));
    end
    in_valid <= 1'b0;

    while (sb.pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
